[hw/rtl/diss_pkg.sv]
`default_nettype none
package diss_pkg;

	// bucket count must be a power of two: the bucket is the low hash bits
	localparam int NUM_BUCKETS = 4096;
	localparam int WAYS        = 4;
	localparam int BKT_W       = $clog2(NUM_BUCKETS);
	localparam int KEY_W       = 128;
	localparam int WAY_W       = KEY_W + 1;
	localparam int ROW_W       = WAYS * WAY_W;
	localparam int SLOT_TOTAL  = NUM_BUCKETS * WAYS;
	localparam int CNT_W       = $clog2(SLOT_TOTAL + 1);
	localparam int OCC_W       = 15;
	localparam int OCC_MAX     = 32767;
	localparam int HASH_BYTES  = 16;
	localparam int BCNT_W      = $clog2(HASH_BYTES);

	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [1:0] ST_NEW  = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic clr_wr;
		logic rd;
		logic decide;
		logic clr_cnt;
		logic clr_respond;
	} diss_cmd_t;

	typedef struct packed {
		logic hash_last;
		logic clr_last;
	} diss_sts_t;

endpackage
`default_nettype wire

[hw/rtl/diss_ram.sv]
`default_nettype none
module diss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/diss_ctrl.sv]
`default_nettype none
module diss_ctrl
	import diss_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      command,
	input  wire diss_sts_t sts,
	output diss_cmd_t      cmd,
	output logic           busy
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_DECIDE
	} state_t;

	state_t state_q;
	logic   user_clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			user_clr_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == CMD_CLEAR) begin
							state_q    <= S_CLR;
							user_clr_q <= 1'b1;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (sts.hash_last) state_q <= S_READ;
				end
				S_READ:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_IDLE;
				S_CLR: begin
					if (sts.clr_last) begin
						state_q    <= S_IDLE;
						user_clr_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == S_IDLE) && start && (command == CMD_INSERT);
		cmd.clr_cnt     = (state_q == S_IDLE) && start && (command == CMD_CLEAR);
		cmd.hash_step   = (state_q == S_HASH);
		cmd.rd          = (state_q == S_READ);
		cmd.decide      = (state_q == S_DECIDE);
		cmd.clr_wr      = (state_q == S_CLR);
		cmd.clr_respond = (state_q == S_CLR) && sts.clr_last && user_clr_q;
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/diss_dp.sv]
`default_nettype none
module diss_dp
	import diss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire diss_cmd_t        cmd,
	input  wire logic [63:0]      dev,
	input  wire logic [63:0]      ino,
	output diss_sts_t             sts,
	output logic                  done,
	output logic [1:0]            status,
	output logic [OCC_W-1:0]      occupancy
);

	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  sh_q;
	logic [31:0]       hash_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic [BKT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [OCC_W-1:0]  occ_q;

	logic [ROW_W-1:0]  rdata;
	logic [ROW_W-1:0]  wrow;
	logic [BKT_W-1:0]  addr;
	logic              ram_en;
	logic              ram_we;
	logic [31:0]       hash_next;
	logic              found;
	logic              have_free;
	logic [WAYS-1:0]   free_sel;
	logic              store;
	logic [CNT_W-1:0]  cnt_next;
	logic [31:0]       cnt_ext;

	// one fnv-1 style byte step: multiply by the fnv prime, then xor in the sign-extended byte
	assign hash_next = (hash_q * HASH_PRIME) ^ {{24{sh_q[7]}}, sh_q[7:0]};

	// bucket compare and lowest free way
	always_comb begin
		found     = 1'b0;
		have_free = 1'b0;
		free_sel  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rdata[w*WAY_W + KEY_W]) begin
				if (rdata[w*WAY_W +: KEY_W] == key_q) found = 1'b1;
			end else if (!have_free) begin
				have_free   = 1'b1;
				free_sel[w] = 1'b1;
			end
		end
	end

	always_comb begin
		wrow = rdata;
		for (int w = 0; w < WAYS; w++) begin
			if (free_sel[w]) wrow[w*WAY_W +: WAY_W] = {1'b1, key_q};
		end
		if (cmd.clr_wr) wrow = '0;
	end

	assign store    = cmd.decide && !found && have_free;
	assign addr     = cmd.clr_wr ? ptr_q : hash_q[BKT_W-1:0];
	assign ram_we   = cmd.clr_wr || store;
	assign ram_en   = ram_we || cmd.rd;
	assign cnt_next = cnt_q + CNT_W'(store);
	assign cnt_ext  = 32'(cnt_next);

	diss_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (addr),
		.wdata(wrow),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= {ino, dev};
			sh_q   <= {ino, dev};
			hash_q <= '0;
			bcnt_q <= '0;
		end else if (cmd.hash_step) begin
			sh_q   <= {8'd0, sh_q[KEY_W-1:8]};
			hash_q <= hash_next;
			bcnt_q <= bcnt_q + BCNT_W'(1);
		end
		if (cmd.decide) begin
			status_q <= found ? ST_DUP : (have_free ? ST_NEW : ST_FULL);
			occ_q    <= (cnt_ext > 32'(OCC_MAX)) ? OCC_W'(OCC_MAX) : OCC_W'(cnt_ext);
		end else if (cmd.clr_respond) begin
			status_q <= ST_NEW;
			occ_q    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.decide || cmd.clr_respond;
			if (cmd.clr_wr) ptr_q <= ptr_q + BKT_W'(1);
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (store) begin
				cnt_q <= cnt_next;
			end
		end
	end

	assign sts.hash_last = (bcnt_q == BCNT_W'(HASH_BYTES - 1));
	assign sts.clr_last  = (ptr_q == BKT_W'(NUM_BUCKETS - 1));
	assign done          = done_q;
	assign status        = status_q;
	assign occupancy     = occ_q;

endmodule
`default_nettype wire

[hw/rtl/dev_inode_seen_set.sv]
// insert: 16 hash byte steps through one multiplier, then bucket row read,
//   compare and write-back, and the output register; one item at a time
// clear: one bucket row zeroed per cycle through the ram port
// after reset the same clearing pass runs with busy high
// the receiver cannot stall: each result shows for one cycle with done high
`default_nettype none
module dev_inode_seen_set
	import diss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             command,
	input  wire logic [63:0]      dev,
	input  wire logic [63:0]      ino,
	output logic                  done,
	output logic [1:0]            status,
	output logic [OCC_W-1:0]      occupancy
);

	// command and status between the fsm and the datapath
	diss_cmd_t cmd;
	diss_sts_t sts;

	// sequencer: clear sweep, hash steps, row read, decide
	diss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hash unit, bucket ram, way compare, key count and result registers
	diss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dev      (dev),
		.ino      (ino),
		.sts      (sts),
		.done     (done),
		.status   (status),
		.occupancy(occupancy)
	);

endmodule
`default_nettype wire

[sim/dev_inode_seen_set_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module dev_inode_seen_set_tb;
	import diss_pkg::*;

	// idle cycles without any item or result before the run is abandoned;
	// a clear or the clearing pass after reset sweeps all NUM_BUCKETS rows
	localparam int STALL_LIMIT = 4 * NUM_BUCKETS + 2000;
	localparam int N_RANDOM    = 1130;
	localparam int N_HOT       = 4;   // buckets driven into overflow on purpose
	localparam int HOT_KEYS    = 7;   // keys per hot bucket, more than WAYS

	// golden model of the set plus the queue of pending results
	class seen_set_scoreboard;
		bit             valid_q [SLOT_TOTAL];
		bit [63:0]      dev_q   [SLOT_TOTAL];
		bit [63:0]      ino_q   [SLOT_TOTAL];
		int             key_cnt;
		bit [1:0]       exp_status [$];
		bit [OCC_W-1:0] exp_occ    [$];
		int             mismatches;
		int             n_new, n_dup, n_full, n_clear;

		// fnv-1 style hash from zero over dev then ino, bytes low first, byte sign-extended before xor
		function bit [31:0] key_hash(bit [63:0] d, bit [63:0] i);
			bit [31:0]  h;
			bit [127:0] k;
			bit [7:0]   b;
			h = '0;
			k = {i, d};
			for (int n = 0; n < HASH_BYTES; n++) begin
				b = k[8*n +: 8];
				h = h * HASH_PRIME;
				h ^= {{24{b[7]}}, b};
			end
			return h;
		endfunction

		function int bucket_of(bit [63:0] d, bit [63:0] i);
			return int'(key_hash(d, i) % NUM_BUCKETS);
		endfunction

		function bit [OCC_W-1:0] occ_now();
			return (key_cnt > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(key_cnt);
		endfunction

		// one accepted item: update the set and queue the result it must give
		function void note_item(bit cmd, bit [63:0] d, bit [63:0] i);
			int  base;
			int  free_at;
			bit  hit;
			if (cmd == CMD_CLEAR) begin
				foreach (valid_q[s]) valid_q[s] = 1'b0;
				key_cnt = 0;
				n_clear++;
				exp_status.push_back(ST_NEW);
				exp_occ.push_back('0);
				return;
			end
			base    = bucket_of(d, i) * WAYS;
			free_at = -1;
			hit     = 1'b0;
			for (int w = 0; w < WAYS; w++) begin
				if (valid_q[base+w]) begin
					if (dev_q[base+w] == d && ino_q[base+w] == i) hit = 1'b1;
				end else if (free_at < 0) begin
					free_at = base + w;
				end
			end
			if (hit) begin
				n_dup++;
				exp_status.push_back(ST_DUP);
			end else if (free_at < 0) begin
				n_full++;
				exp_status.push_back(ST_FULL);
			end else begin
				valid_q[free_at] = 1'b1;
				dev_q[free_at]   = d;
				ino_q[free_at]   = i;
				key_cnt++;
				n_new++;
				exp_status.push_back(ST_NEW);
			end
			exp_occ.push_back(occ_now());
		endfunction

		function void check_result(bit [1:0] st, bit [OCC_W-1:0] occ);
			bit [1:0]       es;
			bit [OCC_W-1:0] eo;
			if (exp_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: unexpected result status=%0d occupancy=%0d", st, occ);
				return;
			end
			es = exp_status.pop_front();
			eo = exp_occ.pop_front();
			if (st !== es || occ !== eo) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: status exp %0d got %0d, occupancy exp %0d got %0d",
						es, st, eo, occ);
			end
		endfunction

		function int pending();
			return exp_status.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             command = CMD_INSERT;
	logic [63:0]      dev = '0;
	logic [63:0]      ino = '0;
	wire logic        busy;
	wire logic        done;
	wire logic [1:0]  status;
	wire logic [OCC_W-1:0] occupancy;

	dev_inode_seen_set dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.dev       (dev),
		.ino       (ino),
		.done      (done),
		.status    (status),
		.occupancy (occupancy)
	);

	seen_set_scoreboard sb = new();

	// keys that were offered before, replayed to provoke duplicates
	bit [63:0] seen_dev [$];
	bit [63:0] seen_ino [$];
	// keys that all land in one of a few chosen buckets, to fill them up
	bit [63:0] hot_dev [N_HOT][HOT_KEYS];
	bit [63:0] hot_ino [N_HOT][HOT_KEYS];
	int        stall_cnt;

	initial begin
		forever #5 clk = ~clk;
	end

	// monitor: everything is sampled at the edge, before any update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(status, occupancy);
			if (start && !busy) sb.note_item(command, dev, ino);
			if (done || (start && !busy)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("error: no progress for %0d cycles", STALL_LIMIT);
				$display("FAIL");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end else begin
			stall_cnt <= 0;
		end
	end

	// mostly short gaps, some none at all, now and then a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function bit [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// offer one item and hold it until the block takes it;
	// start stays high into the next item when no gap follows
	task send_item(bit cmd, bit [63:0] d, bit [63:0] i);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		dev     <= d;
		ino     <= i;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (cmd == CMD_INSERT && seen_dev.size() < 400) begin
			seen_dev.push_back(d);
			seen_ino.push_back(i);
		end
	endtask

	// a clear carries random junk in dev and ino, which must be ignored
	task send_clear();
		send_item(CMD_CLEAR, rand64(), rand64());
	endtask

	// brute search, for each hot bucket b, for keys that hash into bucket b*1237 mod NUM_BUCKETS
	task find_hot_keys();
		bit [63:0] d, i;
		for (int b = 0; b < N_HOT; b++) begin
			for (int k = 0; k < HOT_KEYS; k++) begin
				do begin
					d = (b == 0) ? 64'($urandom_range(0, 255)) : rand64();
					i = rand64();
				end while (sb.bucket_of(d, i) != (b * 1237) % NUM_BUCKETS);
				hot_dev[b][k] = d;
				hot_ino[b][k] = i;
			end
		end
	endtask

	task directed_items();
		// extremes of the key; the all-zero and all-one keys go twice so the second is a duplicate
		send_item(CMD_INSERT, '0, '0);
		send_item(CMD_INSERT, '1, '1);
		send_item(CMD_INSERT, '0, '1);
		send_item(CMD_INSERT, '1, '0);
		send_item(CMD_INSERT, 64'h8080_8080_8080_8080, 64'h7f7f_7f7f_7f7f_7f7f);
		send_item(CMD_INSERT, '0, '0);
		send_item(CMD_INSERT, '1, '1);
		// fill one bucket past its ways: the tail overflows, then duplicates still hit
		for (int k = 0; k < HOT_KEYS; k++) send_item(CMD_INSERT, hot_dev[0][k], hot_ino[0][k]);
		send_item(CMD_INSERT, hot_dev[0][0], hot_ino[0][0]);
		send_item(CMD_INSERT, hot_dev[0][WAYS-1], hot_ino[0][WAYS-1]);
		send_item(CMD_INSERT, hot_dev[0][WAYS], hot_ino[0][WAYS]);
		// clear, then the same keys come back as new
		send_clear();
		send_item(CMD_INSERT, '1, '1);
		send_item(CMD_INSERT, hot_dev[0][WAYS], hot_ino[0][WAYS]);
		send_clear();
		send_clear();
	endtask

	task random_items();
		int r, k, b;
		for (int n = 0; n < N_RANDOM; n++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_clear();
			end else if (r < 40) begin
				send_item(CMD_INSERT, rand64(), rand64());
			end else if (r < 65 && seen_dev.size() > 0) begin
				k = $urandom_range(0, seen_dev.size() - 1);
				send_item(CMD_INSERT, seen_dev[k], seen_ino[k]);
			end else if (r < 90) begin
				b = $urandom_range(0, N_HOT - 1);
				k = $urandom_range(0, HOT_KEYS - 1);
				send_item(CMD_INSERT, hot_dev[b][k], hot_ino[b][k]);
			end else begin
				// near miss: one key half from a hot key, the other flipped in one bit
				b = $urandom_range(0, N_HOT - 1);
				k = $urandom_range(0, HOT_KEYS - 1);
				send_item(CMD_INSERT, hot_dev[b][k] ^ (64'd1 << $urandom_range(0, 63)),
					hot_ino[b][k]);
			end
		end
	endtask

	initial begin
		find_hot_keys();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		random_items();
		start <= 1'b0;
		// let the monitor note the last item, then drain every outstanding result
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d new keys, %0d duplicates, %0d overflows, %0d clears",
			sb.n_new, sb.n_dup, sb.n_full, sb.n_clear);
		$display("%0d mismatches", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
